FILE: rtl/core/pib_pkg.sv
// Package for the palette index bit packer.
// Holds the shared widths, the front-to-back event type and the width helper.
// No dependencies.
package pib_pkg;

    localparam int IDX_BITS = 16;
    localparam int CFG_BITS = 17;
    localparam int OUT_BITS = 64;
    localparam int LEN_W    = 5;

    // One event from the packer front: an optional full word, then an
    // optional flushed partial word (always the final word of its array).
    typedef struct packed {
        logic                full_v;
        logic                full_final;
        logic [OUT_BITS-1:0] full_word;
        logic                part_v;
        logic [OUT_BITS-1:0] part_word;
    } t_event;

    // Bit length of (count - 1), with counts below two taken as two.
    function automatic logic [LEN_W-1:0] pib_elem_len(input logic [CFG_BITS-1:0] count);
        logic [CFG_BITS-1:0] top;
        logic [LEN_W-1:0]    len;
        top = (count < CFG_BITS'(2)) ? CFG_BITS'(1) : (count - CFG_BITS'(1));
        len = '0;
        for (int i = 0; i < CFG_BITS; i++) begin
            if (top[i]) begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

FILE: rtl/core/palette_index_bit_packer_core.sv
// Top level of the palette index bit packer.
// Depends on pib_pkg, pib_front, pib_queue and pib_back.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------
//  input     | push / full           | i_index_value, i_last_element
//  result    | empty / pop           | o_packed_word, o_final_word
//  config    | i_cfg_we              | i_cfg_wdata (palette count)
//
// One index is taken every cycle while the event queue has room; the packer
// front does its shift-and-or and the word split in that same cycle.
// The result side moves one word per cycle while pop is given, so an index that
// both fills a word and flushes a partial one yields two result words; the event
// queue of QUEUE_DEPTH entries absorbs such bursts.
// Reset is synchronous: it empties the queue and the output register, clears
// the accumulator and sets the element width to one bit.
// A stalled result side backs up into the queue, then raises full.
module palette_index_bit_packer_core #(
    parameter int WORD_BITS        = 64,
    parameter int MAX_ELEMENT_BITS = 16,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [pib_pkg::IDX_BITS-1:0]  i_index_value,
    input  logic                          i_last_element,
    output logic                          empty,
    input  logic                          pop,
    output logic [pib_pkg::OUT_BITS-1:0]  o_packed_word,
    output logic                          o_final_word,
    input  logic                          i_cfg_we,
    input  logic [pib_pkg::CFG_BITS-1:0]  i_cfg_wdata
);
    import pib_pkg::*;

    logic   accept;
    logic   ev_push;
    t_event ev_in;
    t_event ev_out;
    logic   q_empty;
    logic   ev_take;

    // Take an index only when the queue can hold its event.
    assign accept = push && !full;

    pib_front #(
        .WORD_BITS        (WORD_BITS),
        .MAX_ELEMENT_BITS (MAX_ELEMENT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_index_value  (i_index_value),
        .i_last_element (i_last_element),
        .o_ev_push      (ev_push),
        .o_ev           (ev_in)
    );

    // Events that carry no word are dropped at the front.
    pib_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (ev_push),
        .i_wr_data (ev_in),
        .o_full    (full),
        .i_rd_en   (ev_take),
        .o_rd_data (ev_out),
        .o_empty   (q_empty)
    );

    pib_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ev          (ev_out),
        .i_ev_ready    (!q_empty),
        .o_ev_take     (ev_take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_packed_word (o_packed_word),
        .o_final_word  (o_final_word)
    );

endmodule

FILE: rtl/core/pib_front.sv
// Packer front: holds the element width and the bit accumulator, and turns
// each accepted index into one event of up to two words. Uses pib_pkg.
module pib_front #(
    parameter int WORD_BITS        = 64,
    parameter int MAX_ELEMENT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pib_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    input  logic                          i_accept,
    input  logic [pib_pkg::IDX_BITS-1:0]  i_index_value,
    input  logic                          i_last_element,
    output logic                          o_ev_push,
    output pib_pkg::t_event               o_ev
);
    import pib_pkg::*;

    localparam int FILL_W = $clog2(WORD_BITS);
    localparam int SUM_W  = FILL_W + 1;
    localparam int EB_W   = $clog2(MAX_ELEMENT_BITS + 1);
    localparam int EXT_W  = WORD_BITS + IDX_BITS;

    logic [EB_W-1:0]      r_elem_bits;
    logic [EB_W-1:0]      n_elem_bits;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] n_acc;
    logic [FILL_W-1:0]    r_filled;
    logic [FILL_W-1:0]    n_filled;

    logic [LEN_W-1:0]     cfg_len;
    logic [IDX_BITS-1:0]  val_mask;
    logic [IDX_BITS-1:0]  val;
    logic [EXT_W-1:0]     ext;
    logic [WORD_BITS-1:0] acc_or;
    logic [WORD_BITS-1:0] spill_acc;
    logic [SUM_W-1:0]     total;
    logic                 wrap;
    logic [FILL_W-1:0]    step_filled;
    logic [WORD_BITS-1:0] step_acc;

    // Width from the written count, saturated at the widest element.
    always_comb begin
        cfg_len = pib_elem_len(i_cfg_wdata);
        if (int'(cfg_len) > MAX_ELEMENT_BITS) begin
            n_elem_bits = EB_W'(MAX_ELEMENT_BITS);
        end else begin
            n_elem_bits = EB_W'(cfg_len);
        end
    end

    always_comb begin
        for (int i = 0; i < IDX_BITS; i++) begin
            val_mask[i] = (i < int'(r_elem_bits));
        end
        val       = i_index_value & val_mask;
        ext       = EXT_W'(val) << r_filled;
        acc_or    = r_acc | ext[WORD_BITS-1:0];
        spill_acc = WORD_BITS'(ext[EXT_W-1:WORD_BITS]);
        total     = SUM_W'(r_filled) + SUM_W'(r_elem_bits);
        wrap      = (total >= SUM_W'(WORD_BITS));
        if (wrap) begin
            step_filled = FILL_W'(total - SUM_W'(WORD_BITS));
            step_acc    = spill_acc;
        end else begin
            step_filled = FILL_W'(total);
            step_acc    = acc_or;
        end
    end

    always_comb begin
        o_ev.full_v     = wrap;
        o_ev.full_final = i_last_element && (step_filled == '0);
        o_ev.full_word  = OUT_BITS'(acc_or);
        o_ev.part_v     = i_last_element && (step_filled != '0);
        o_ev.part_word  = OUT_BITS'(step_acc);
        o_ev_push       = i_accept && (o_ev.full_v || o_ev.part_v);
        if (i_last_element) begin
            n_acc    = '0;
            n_filled = '0;
        end else begin
            n_acc    = step_acc;
            n_filled = step_filled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_bits <= EB_W'(1);
            r_acc       <= '0;
            r_filled    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_elem_bits <= n_elem_bits;
            end
            if (i_accept) begin
                r_acc    <= n_acc;
                r_filled <= n_filled;
            end
        end
    end

endmodule

FILE: rtl/core/pib_queue.sv
// Short event queue between the packer front and the output back.
// Uses pib_pkg for the event type.
module pib_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  pib_pkg::t_event i_wr_data,
    output logic            o_full,
    input  logic            i_rd_en,
    output pib_pkg::t_event o_rd_data,
    output logic            o_empty
);
    import pib_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_fire;
    logic             rd_fire;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_fire   = i_wr_en && !o_full;
    assign rd_fire   = i_rd_en && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_fire) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({wr_fire, rd_fire})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/pib_back.sv
// Output back: splits each event into words and presents them one at a time
// from an output register, with a holding slot for the second word. Uses pib_pkg.
module pib_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pib_pkg::t_event               i_ev,
    input  logic                          i_ev_ready,
    output logic                          o_ev_take,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [pib_pkg::OUT_BITS-1:0]  o_packed_word,
    output logic                          o_final_word
);
    import pib_pkg::*;

    logic                r_out_v;
    logic [OUT_BITS-1:0] r_out_word;
    logic                r_out_final;
    logic                r_hold_v;
    logic [OUT_BITS-1:0] r_hold_word;
    logic                slot_free;

    assign o_empty       = !r_out_v;
    assign o_packed_word = r_out_word;
    assign o_final_word  = r_out_final;
    assign slot_free     = !r_out_v || i_pop;
    assign o_ev_take     = slot_free && !r_hold_v && i_ev_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (slot_free) begin
            if (r_hold_v) begin
                r_out_v  <= 1'b1;
                r_hold_v <= 1'b0;
            end else if (i_ev_ready) begin
                r_out_v  <= 1'b1;
                r_hold_v <= i_ev.full_v && i_ev.part_v;
            end else begin
                r_out_v  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_hold_v) begin
                r_out_word  <= r_hold_word;
                r_out_final <= 1'b1;
            end else if (i_ev_ready) begin
                r_hold_word <= i_ev.part_word;
                if (i_ev.full_v) begin
                    r_out_word  <= i_ev.full_word;
                    r_out_final <= i_ev.full_final;
                end else begin
                    r_out_word  <= i_ev.part_word;
                    r_out_final <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/pib_checker.sv
// Port-level checks for the palette index bit packer, bound to the top level.
// Uses pib_pkg for port widths.
module pib_checker #(
    parameter int WORD_BITS = 64
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [pib_pkg::OUT_BITS-1:0]  o_packed_word,
    input logic                          o_final_word
);
    import pib_pkg::*;

    // Reset leaves nothing queued and room for input.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not empty or full after reset");

    // A waiting result holds until it is taken.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_packed_word) && $stable(o_final_word)))
        else $error("waiting result changed");

    // Stream bits never reach above the word width.
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_packed_word >> WORD_BITS) == '0))
        else $error("bits above word width set");

    // The queue only fills up behind a result that is already shown.
    a_full_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("full with no result shown");

endmodule

bind palette_index_bit_packer_core pib_checker #(
    .WORD_BITS (WORD_BITS)
) u_pib_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_packed_word (o_packed_word),
    .o_final_word  (o_final_word)
);

FILE: tb/palette_index_bit_packer_core_tb.sv
// Self-checking testbench for palette_index_bit_packer_core: directed and random index streams.
// Predicts every packed word in-bench and checks each popped word against it, field by field.
// Depends on pib_pkg and the packer RTL.
module palette_index_bit_packer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pib_pkg::*;

    localparam int MAX_ELEM    = 16;
    localparam int SETTLE_CYC  = 10;  // queue depth plus output register, with margin

    typedef struct {
        logic [IDX_BITS-1:0] idx;
        logic                last;
    } t_index_item;

    typedef struct {
        logic [OUT_BITS-1:0] word;
        logic                last_word;
    } t_packed_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [IDX_BITS-1:0] i_index_value = '0;
    logic                i_last_element = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [OUT_BITS-1:0] o_packed_word;
    logic                o_final_word;
    logic                i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_wdata = '0;

    // Items waiting to be pushed, and the words the packer owes us, oldest first.
    t_index_item  index_backlog[$];
    t_packed_word words_due[$];
    t_index_item  cur_item;

    // Shadow of the packer: accumulator, its fill level and the palette count.
    logic [OUT_BITS-1:0] acc_bits = '0;
    int unsigned         acc_fill = 0;
    logic [CFG_BITS-1:0] pal_count = CFG_BITS'(2);

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_cnt  = 0;

    palette_index_bit_packer_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_index_value  (i_index_value),
        .i_last_element (i_last_element),
        .empty          (empty),
        .pop            (pop),
        .o_packed_word  (o_packed_word),
        .o_final_word   (o_final_word),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Element width: bit length of (count - 1), counts below two act as two,
    // and the width saturates at MAX_ELEM.
    function automatic int bits_per_index(input logic [CFG_BITS-1:0] count);
        logic [CFG_BITS-1:0] top;
        int                  nb;
        top = (count < CFG_BITS'(2)) ? CFG_BITS'(1) : count - CFG_BITS'(1);
        nb  = 0;
        while (top != '0) begin
            nb++;
            top = top >> 1;
        end
        return (nb > MAX_ELEM) ? MAX_ELEM : nb;
    endfunction

    // Append one index to the shadow stream and queue the words it completes:
    // a word that just filled, then on the last element the flushed remainder.
    task automatic pack_index(input logic [IDX_BITS-1:0] idx, input logic last);
        int                  nb;
        int unsigned         total;
        int unsigned         spill;
        logic [OUT_BITS-1:0] val;
        logic [OUT_BITS-1:0] full_w;
        bit                  have_full;
        nb        = bits_per_index(pal_count);
        val       = OUT_BITS'(idx) & ((OUT_BITS'(1) << nb) - OUT_BITS'(1));
        acc_bits  = acc_bits | (val << acc_fill);
        total     = acc_fill + nb;
        have_full = 1'b0;
        full_w    = '0;
        if (total >= OUT_BITS) begin
            spill     = total - OUT_BITS;
            full_w    = acc_bits;
            have_full = 1'b1;
            acc_bits  = (spill != 0) ? (val >> (nb - spill)) : '0;
            acc_fill  = spill;
        end else begin
            acc_fill = total;
        end
        if (!last) begin
            if (have_full) words_due.push_back('{full_w, 1'b0});
        end else begin
            // A word filled exactly by the last element carries the final flag itself.
            if (acc_fill != 0) begin
                if (have_full) words_due.push_back('{full_w, 1'b0});
                words_due.push_back('{acc_bits, 1'b1});
            end else if (have_full) begin
                words_due.push_back('{full_w, 1'b1});
            end
            acc_bits = '0;
            acc_fill = 0;
        end
    endtask

    // Driver: predict on acceptance, then hold, advance or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                pack_index(cur_item.idx, cur_item.last);
            end
            if (!push || !full) begin
                if (index_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = index_backlog.pop_front();
                    push           <= 1'b1;
                    i_index_value  <= cur_item.idx;
                    i_last_element <= cur_item.last;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each popped word against the oldest one due, stall at random.
    always @(posedge i_clk) begin
        t_packed_word due;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (words_due.size() == 0) begin
                    $display("%0t: unexpected word: expected none, got %h final %0b",
                             $realtime, o_packed_word, o_final_word);
                    mismatch_cnt++;
                end else begin
                    due = words_due.pop_front();
                    if (o_packed_word !== due.word) begin
                        $display("%0t: packed_word: expected %h, got %h",
                                 $realtime, due.word, o_packed_word);
                        mismatch_cnt++;
                    end
                    if (o_final_word !== due.last_word) begin
                        $display("%0t: final_word: expected %0b, got %0b",
                                 $realtime, due.last_word, o_final_word);
                        mismatch_cnt++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send(input logic [IDX_BITS-1:0] idx, input logic last);
        index_backlog.push_back('{idx, last});
    endtask

    // Hold off until every item is in and every word due has come out, then
    // let the pipe settle so a non-emitting item is fully absorbed.
    task automatic drain();
        while (index_backlog.size() != 0 || push || words_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_palette(input logic [CFG_BITS-1:0] count);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        pal_count = count;
        @(negedge i_clk);
    endtask

    // One random phase: new palette count, then arrays of random length.
    // The phase may stop mid-array, so the next width change lands mid-array.
    task automatic random_phase(input int n_items);
        logic [CFG_BITS-1:0] count;
        logic [IDX_BITS-1:0] idx;
        int                  nb;
        int                  run;
        int                  left;
        case ($urandom_range(9))
            0: count = CFG_BITS'($urandom_range(1));
            1: count = CFG_BITS'(65536);
            2: count = CFG_BITS'($urandom_range(131071, 65537));
            default: begin
                nb    = $urandom_range(16, 1);
                count = CFG_BITS'((1 << (nb - 1)) + $urandom_range(1 << (nb - 1), 1));
            end
        endcase
        write_palette(count);
        left = n_items;
        run  = 0;
        while (left > 0) begin
            if (run == 0) begin
                run = ($urandom_range(9) < 2) ? $urandom_range(3, 1) : $urandom_range(40, 4);
            end
            case ($urandom_range(7))
                0:       idx = '1;
                1:       idx = '0;
                default: idx = IDX_BITS'($urandom);
            endcase
            // Occasionally cut an array short to shake up the flush timing.
            send(idx, (run == 1) || ($urandom_range(49) == 0));
            run  = index_backlog[$].last ? 0 : run - 1;
            left--;
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 23;
        recv_idle_pct = 58;

        // Reset width of one bit: extremes of the index, short array flushed.
        send(16'hFFFF, 1'b0);
        send(16'h0000, 1'b0);
        send(16'hFFFE, 1'b0);
        send(16'h0001, 1'b1);
        drain();

        // Full 16-bit width; four elements fill the word exactly on the last one.
        write_palette(CFG_BITS'(65536));
        send(16'hFFFF, 1'b0);
        send(16'h0000, 1'b0);
        send(16'hA5A5, 1'b0);
        send(16'h5A5A, 1'b1);
        drain();

        // Change the width mid-array; counts of zero and one fall back to one bit.
        send(16'h1234, 1'b0);
        send(16'hFFFF, 1'b0);
        drain();
        write_palette(CFG_BITS'(0));
        send(16'h0001, 1'b0);
        send(16'hFFFF, 1'b0);
        drain();
        write_palette(CFG_BITS'(1));
        send(16'h0001, 1'b1);
        drain();

        // Count past the top of the palette saturates the width.
        write_palette(CFG_BITS'(17'h1FFFF));
        send(16'h0001, 1'b0);
        send(16'h8000, 1'b1);
        drain();

        // 14-bit elements: the fifth straddles the word, so a full word and a flush.
        write_palette(CFG_BITS'(8193));
        send(16'h3FFF, 1'b0);
        send(16'hC000, 1'b0);
        send(16'h2AAA, 1'b0);
        send(16'h1555, 1'b0);
        send(16'hFFFF, 1'b1);
        drain();

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        for (int ph = 0; ph < 15; ph++) begin
            if (ph == 5) begin
                send_idle_pct = 58;
                recv_idle_pct = 23;
            end else if (ph == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase(50);
        end

        repeat (SETTLE_CYC) @(negedge i_clk);
        if (mismatch_cnt == 0 && words_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #400_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: palette_index_bit_packer_core.f
rtl/core/pib_pkg.sv
rtl/core/pib_front.sv
rtl/core/pib_queue.sv
rtl/core/pib_back.sv
rtl/core/palette_index_bit_packer_core.sv
rtl/core/pib_checker.sv
tb/palette_index_bit_packer_core_tb.sv
